@@ src/lfu_cwr_pkg.sv @@
// Shared types, constants and helper functions for the LFU way replacement unit.
`timescale 1ns / 1ps
`default_nettype none

package lfu_cwr_pkg;

    // Cache geometry
    localparam int WAYS       = 4;
    localparam int SETS       = 256;
    localparam int TAG_BITS   = 20;
    localparam int COUNT_BITS = 16;

    // Fixed port field widths
    localparam int SET_IN_BITS  = 8;
    localparam int TAG_IN_BITS  = 20;
    localparam int WAY_OUT_BITS = 2;
    localparam int STATUS_BITS  = 3;

    localparam int SET_BITS = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int SET_SPAN = 2 ** SET_IN_BITS;

    typedef logic [TAG_BITS-1:0]   t_tag;
    typedef logic [COUNT_BITS-1:0] t_count;
    typedef logic [WAY_BITS-1:0]   t_way;
    typedef logic [SET_BITS-1:0]   t_set;

    // One cache line's bookkeeping; a row holds all ways of a set
    typedef struct packed {
        logic   valid;
        logic   locked;
        t_tag   tag;
        t_count count;
    } t_line;

    typedef t_line [WAYS-1:0] t_row;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_HIT        = 3'd0,
        ST_FILL       = 3'd1,
        ST_REPLACE    = 3'd2,
        ST_ALL_LOCKED = 3'd3,
        ST_ERROR      = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EVAL
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic clr_wr;
        logic rd_en;
        logic eval;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic clr_last;
    } t_sts;

    localparam t_count COUNT_MAX = '1;
    localparam t_set   SET_LAST  = t_set'(SETS - 1);

    // Set index reduction table, built at elaboration
    typedef t_set t_set_tbl [SET_SPAN];

    function automatic t_set_tbl f_set_tbl();
        t_set_tbl tbl;
        for (int i = 0; i < SET_SPAN; i++) begin
            tbl[i] = t_set'(i % SETS);
        end
        return tbl;
    endfunction

    localparam t_set_tbl SET_MOD = f_set_tbl();

    // Fit the incoming tag to the stored tag width
    function automatic t_tag f_tag(logic [TAG_IN_BITS-1:0] t);
        logic [TAG_BITS+TAG_IN_BITS-1:0] wide;
        wide = {{TAG_BITS{1'b0}}, t};
        return wide[TAG_BITS-1:0];
    endfunction

    // Fit a way number to the output field
    function automatic logic [WAY_OUT_BITS-1:0] f_way_out(t_way w);
        logic [WAY_OUT_BITS+WAY_BITS-1:0] wide;
        wide = {{WAY_OUT_BITS{1'b0}}, w};
        return wide[WAY_OUT_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

@@ src/lfu_cwr_ctrl.sv @@
// Controller state machine: clearing pass, item accept, row read and evaluate.
`timescale 1ns / 1ps
`default_nettype none

module lfu_cwr_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire lfu_cwr_pkg::t_sts i_sts,
    output logic                   o_busy,
    output lfu_cwr_pkg::t_cmd      o_cmd
);

    lfu_cwr_pkg::t_state r_state;
    lfu_cwr_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lfu_cwr_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        case (r_state)
            lfu_cwr_pkg::S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = lfu_cwr_pkg::S_IDLE;
                end
            end
            lfu_cwr_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = lfu_cwr_pkg::S_READ;
                end
            end
            lfu_cwr_pkg::S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = lfu_cwr_pkg::S_EVAL;
            end
            lfu_cwr_pkg::S_EVAL: begin
                // write-back happens here, so the next item may already load
                o_busy     = 1'b0;
                o_cmd.eval = 1'b1;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = lfu_cwr_pkg::S_READ;
                end else begin
                    n_state = lfu_cwr_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = lfu_cwr_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/lfu_cwr_dp.sv @@
// Datapath: set row memory, way scan with LFU victim pick, row update and result register.
`timescale 1ns / 1ps
`default_nettype none

module lfu_cwr_dp (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_rst_n,
    input  wire lfu_cwr_pkg::t_cmd                       i_cmd,
    input  wire logic                                    i_action,
    input  wire logic [lfu_cwr_pkg::SET_IN_BITS-1:0]     i_set_index,
    input  wire logic [lfu_cwr_pkg::TAG_IN_BITS-1:0]     i_tag,
    output lfu_cwr_pkg::t_sts                            o_sts,
    output logic                                         o_result_valid,
    output logic [lfu_cwr_pkg::STATUS_BITS-1:0]          o_status,
    output logic [lfu_cwr_pkg::WAY_OUT_BITS-1:0]         o_way_used
);

    // Item registers
    logic                  r_action;
    lfu_cwr_pkg::t_set     r_set;
    lfu_cwr_pkg::t_tag     r_tag;

    // Row memory and its registered read port
    lfu_cwr_pkg::t_row     r_mem [lfu_cwr_pkg::SETS];
    lfu_cwr_pkg::t_row     r_rd_row;

    // Clearing pass address
    lfu_cwr_pkg::t_set     r_clr_addr;
    lfu_cwr_pkg::t_set     n_clr_addr;

    // Scan results
    lfu_cwr_pkg::t_row     n_row;
    lfu_cwr_pkg::t_status  n_status;
    lfu_cwr_pkg::t_way     n_way;
    logic                  decided;
    logic                  have_victim;
    lfu_cwr_pkg::t_way     victim;
    lfu_cwr_pkg::t_count   victim_count;

    // Write port select
    logic                  wr_en;
    lfu_cwr_pkg::t_set     wr_addr;
    lfu_cwr_pkg::t_row     wr_row;

    // Result registers
    logic                  r_out_valid;
    lfu_cwr_pkg::t_status  r_status;
    logic [lfu_cwr_pkg::WAY_OUT_BITS-1:0] r_way_used;

    // Capture the item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_set    <= lfu_cwr_pkg::SET_MOD[i_set_index];
            r_tag    <= lfu_cwr_pkg::f_tag(i_tag);
        end
    end

    // Clearing pass counter
    assign n_clr_addr = lfu_cwr_pkg::t_set'(r_clr_addr + 1'b1);
    assign o_sts.clr_last = (r_clr_addr == lfu_cwr_pkg::SET_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= n_clr_addr;
        end
    end

    // Way scan: first invalid or matching way decides, else LFU unlocked victim
    always_comb begin
        decided      = 1'b0;
        have_victim  = 1'b0;
        victim       = '0;
        victim_count = '0;
        n_status     = lfu_cwr_pkg::ST_ALL_LOCKED;
        n_way        = '0;
        for (int w = 0; w < lfu_cwr_pkg::WAYS; w++) begin
            if (!decided) begin
                if (r_rd_row[w].valid) begin
                    if (r_rd_row[w].tag == r_tag) begin
                        n_status = lfu_cwr_pkg::ST_HIT;
                        n_way    = lfu_cwr_pkg::t_way'(w);
                        decided  = 1'b1;
                    end else if (!r_rd_row[w].locked &&
                                 (!have_victim || r_rd_row[w].count < victim_count)) begin
                        have_victim  = 1'b1;
                        victim       = lfu_cwr_pkg::t_way'(w);
                        victim_count = r_rd_row[w].count;
                    end
                end else begin
                    if (r_rd_row[w].locked) begin
                        n_status = lfu_cwr_pkg::ST_ERROR;
                        n_way    = '0;
                    end else begin
                        n_status = lfu_cwr_pkg::ST_FILL;
                        n_way    = lfu_cwr_pkg::t_way'(w);
                    end
                    decided = 1'b1;
                end
            end
        end
        if (!decided && have_victim) begin
            n_status = lfu_cwr_pkg::ST_REPLACE;
            n_way    = victim;
        end
    end

    // Row update for write-back
    always_comb begin
        n_row = r_rd_row;
        case (n_status)
            lfu_cwr_pkg::ST_HIT: begin
                if (r_rd_row[n_way].count != lfu_cwr_pkg::COUNT_MAX) begin
                    n_row[n_way].count =
                        lfu_cwr_pkg::t_count'(r_rd_row[n_way].count + 1'b1);
                end
            end
            lfu_cwr_pkg::ST_FILL, lfu_cwr_pkg::ST_REPLACE: begin
                n_row[n_way].valid = 1'b1;
                n_row[n_way].tag   = r_tag;
                n_row[n_way].count = '0;
            end
            default: begin
            end
        endcase
        if (r_action && (n_status == lfu_cwr_pkg::ST_HIT ||
                         n_status == lfu_cwr_pkg::ST_FILL ||
                         n_status == lfu_cwr_pkg::ST_REPLACE)) begin
            n_row[n_way].locked = 1'b1;
        end
    end

    // Memory port: clearing pass or write-back, registered read
    assign wr_en   = i_cmd.clr_wr || i_cmd.eval;
    assign wr_addr = i_cmd.clr_wr ? r_clr_addr : r_set;
    assign wr_row  = i_cmd.clr_wr ? '0 : n_row;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_row;
        end
        if (i_cmd.rd_en) begin
            r_rd_row <= r_mem[r_set];
        end
    end

    // Result register and strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_cmd.eval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_status   <= n_status;
            r_way_used <= lfu_cwr_pkg::f_way_out(n_way);
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_status       = r_status;
    assign o_way_used     = r_way_used;

endmodule

`default_nettype wire

@@ src/lfu_cache_way_replacement_unit.sv @@
// Top level of the LFU cache way replacement unit with line locking.
`timescale 1ns / 1ps
`default_nettype none

// Each item names a set, a tag and an action (lookup/fill or fetch-and-lock).
// An item is taken when start is high and busy is low; it passes through a read
// state, for the registered read of the set's row from the row memory, and an
// evaluate state, to scan the ways, write the row back and load the result
// register. The result shows on o_status / o_way_used with o_result_valid high
// for one cycle; it cannot be held off, so capture it when the strobe is high.
// A new item can be taken in the evaluate state, while the row is written back.
// After reset the block runs a clearing pass over all 256 set rows, one row per
// cycle, and holds busy high until it ends.

module lfu_cache_way_replacement_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic                                i_action,
    input  wire logic [lfu_cwr_pkg::SET_IN_BITS-1:0] i_set_index,
    input  wire logic [lfu_cwr_pkg::TAG_IN_BITS-1:0] i_tag,
    output logic                                     o_result_valid,
    output logic [lfu_cwr_pkg::STATUS_BITS-1:0]      o_status,
    output logic [lfu_cwr_pkg::WAY_OUT_BITS-1:0]     o_way_used
);

    lfu_cwr_pkg::t_cmd cmd;
    lfu_cwr_pkg::t_sts sts;

    lfu_cwr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_busy  (busy),
        .o_cmd   (cmd)
    );

    lfu_cwr_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_action       (i_action),
        .i_set_index    (i_set_index),
        .i_tag          (i_tag),
        .o_sts          (sts),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_way_used     (o_way_used)
    );

endmodule

`default_nettype wire

@@ src/lfu_cwr_checker.sv @@
// Port-level checker for the LFU cache way replacement unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module lfu_cwr_sva (
    input wire logic                                i_clk,
    input wire logic                                i_rst_n,
    input wire logic                                start,
    input wire logic                                busy,
    input wire logic                                o_result_valid,
    input wire logic [lfu_cwr_pkg::STATUS_BITS-1:0] o_status,
    input wire logic [lfu_cwr_pkg::WAY_OUT_BITS-1:0] o_way_used
);

    // An accepted item blocks the next cycle while its row is read
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after item accept");

    // Every accepted item gives its result strobe
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |-> ##3 o_result_valid)
        else $error("result strobe missing for accepted item");

    // Result strobes are never back to back
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("back-to-back result strobes");

    // No way is reported when nothing was used
    a_way_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_status == lfu_cwr_pkg::ST_ALL_LOCKED ||
                           o_status == lfu_cwr_pkg::ST_ERROR)
        |-> o_way_used == '0)
        else $error("nonzero way on all-locked or error result");

endmodule

bind lfu_cache_way_replacement_unit lfu_cwr_sva u_lfu_cwr_sva (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_status       (o_status),
    .o_way_used     (o_way_used)
);

`default_nettype wire

@@ tb/lfu_cwr_checker.sv @@
// Checker for the LFU way replacement unit: predicts each access outcome and compares results.
`timescale 1ns / 1ps

module lfu_cwr_checker
    import lfu_cwr_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic                    i_busy,
    input  wire logic                    i_action,
    input  wire logic [SET_IN_BITS-1:0]  i_set_index,
    input  wire logic [TAG_IN_BITS-1:0]  i_tag,
    input  wire logic                    i_result_valid,
    input  wire logic [STATUS_BITS-1:0]  i_status,
    input  wire logic [WAY_OUT_BITS-1:0] i_way_used,
    output int                           o_fail_count,
    output int                           o_outstanding
);

    typedef struct {
        t_status                 status;
        logic [WAY_OUT_BITS-1:0] way;
    } t_outcome;

    // Shadow copy of the cache bookkeeping
    logic   shadow_valid  [SETS][WAYS];
    logic   shadow_locked [SETS][WAYS];
    t_tag   shadow_tag    [SETS][WAYS];
    t_count shadow_count  [SETS][WAYS];

    t_outcome expected_outcomes[$];
    int       fail_count = 0;

    assign o_fail_count  = fail_count;
    assign o_outstanding = expected_outcomes.size();

    // Scan the ways of one set and update the shadow state like the block does
    task automatic lfu_access(input logic lock_req, input logic [SET_IN_BITS-1:0] set_in,
                              input logic [TAG_IN_BITS-1:0] tag_in, output t_outcome res);
        int     s;
        t_tag   t;
        bit     decided;
        bit     have_victim;
        int     victim;
        t_count victim_count;
        int     way_sel;
        s            = int'(set_in) % SETS;
        t            = t_tag'(tag_in);
        decided      = 1'b0;
        have_victim  = 1'b0;
        victim       = 0;
        victim_count = '0;
        way_sel      = 0;
        res.status   = ST_ALL_LOCKED;
        for (int w = 0; w < WAYS && !decided; w++) begin
            if (shadow_valid[s][w]) begin
                if (shadow_tag[s][w] == t) begin
                    if (shadow_count[s][w] != COUNT_MAX) begin
                        shadow_count[s][w] = shadow_count[s][w] + 1'b1;
                    end
                    res.status = ST_HIT;
                    way_sel    = w;
                    decided    = 1'b1;
                end else if (!shadow_locked[s][w]) begin
                    // least used unlocked way, strict compare keeps the lowest on ties
                    if (!have_victim || shadow_count[s][w] < victim_count) begin
                        have_victim  = 1'b1;
                        victim       = w;
                        victim_count = shadow_count[s][w];
                    end
                end
            end else begin
                if (shadow_locked[s][w]) begin
                    res.status = ST_ERROR;
                    way_sel    = 0;
                end else begin
                    shadow_tag[s][w]   = t;
                    shadow_valid[s][w] = 1'b1;
                    shadow_count[s][w] = '0;
                    res.status         = ST_FILL;
                    way_sel            = w;
                end
                decided = 1'b1;
            end
        end
        // miss on a full set: evict the victim, if any way is unlocked
        if (!decided) begin
            if (have_victim) begin
                shadow_tag[s][victim]   = t;
                shadow_valid[s][victim] = 1'b1;
                shadow_count[s][victim] = '0;
                res.status              = ST_REPLACE;
                way_sel                 = victim;
            end else begin
                res.status = ST_ALL_LOCKED;
                way_sel    = 0;
            end
        end
        if (lock_req && (res.status == ST_HIT || res.status == ST_FILL ||
                         res.status == ST_REPLACE)) begin
            shadow_locked[s][way_sel] = 1'b1;
        end
        res.way = WAY_OUT_BITS'(way_sel);
    endtask

    // Watch both channels at the rising edge
    always @(posedge i_clk) begin : watch
        t_outcome fresh;
        t_outcome oldest;
        if (!i_rst_n) begin
            for (int s = 0; s < SETS; s++) begin
                for (int w = 0; w < WAYS; w++) begin
                    shadow_valid[s][w]  = 1'b0;
                    shadow_locked[s][w] = 1'b0;
                    shadow_tag[s][w]    = '0;
                    shadow_count[s][w]  = '0;
                end
            end
            expected_outcomes.delete();
        end else begin
            // compare the result strobed in this cycle
            if (i_result_valid) begin
                if (expected_outcomes.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("%0t: unexpected result: status %0d way %0d", $realtime,
                                 i_status, i_way_used);
                    end
                end else begin
                    oldest = expected_outcomes.pop_front();
                    if (i_status !== oldest.status || i_way_used !== oldest.way) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("%0t: mismatch: expected status %0d way %0d, got status %0d way %0d",
                                     $realtime, oldest.status, oldest.way, i_status,
                                     i_way_used);
                        end
                    end
                end
            end
            // predict the item accepted at this edge
            if (i_start && !i_busy) begin
                lfu_access(i_action, i_set_index, i_tag, fresh);
                expected_outcomes.push_back(fresh);
            end
        end
    end

endmodule

@@ tb/testbench.sv @@
// Top of the LFU way replacement testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import lfu_cwr_pkg::*;

    localparam logic ACT_LOOKUP = 1'b0;
    localparam logic ACT_LOCK   = 1'b1;

    localparam logic [SET_IN_BITS-1:0] SAT_SET      = 8'd128;
    localparam int                     RANDOM_ITEMS = 1700;
    localparam int                     CYCLE_LIMIT  = 1_000_000;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    start;
    logic                    busy;
    logic                    i_action;
    logic [SET_IN_BITS-1:0]  i_set_index;
    logic [TAG_IN_BITS-1:0]  i_tag;
    logic                    o_result_valid;
    logic [STATUS_BITS-1:0]  o_status;
    logic [WAY_OUT_BITS-1:0] o_way_used;
    int                      fail_count;
    int                      outstanding;
    int                      cycle_count = 0;

    always #1 i_clk = ~i_clk;

    lfu_cache_way_replacement_unit uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_set_index    (i_set_index),
        .i_tag          (i_tag),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_way_used     (o_way_used)
    );

    lfu_cwr_checker checker_inst (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_action       (i_action),
        .i_set_index    (i_set_index),
        .i_tag          (i_tag),
        .i_result_valid (o_result_valid),
        .i_status       (o_status),
        .i_way_used     (o_way_used),
        .o_fail_count   (fail_count),
        .o_outstanding  (outstanding)
    );

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lfu_cache_way_replacement_unit regression: fail");
            $finish;
        end
    end

    // Present one item from a falling edge and hold it until the block takes it
    task automatic send_item(input logic act, input logic [SET_IN_BITS-1:0] set_in,
                             input logic [TAG_IN_BITS-1:0] tag_in);
        start       <= 1'b1;
        i_action    <= act;
        i_set_index <= set_in;
        i_tag       <= tag_in;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Random pause between items, mostly short, now and then long
    task automatic idle_gap(input bit burst);
        int pick;
        int len;
        pick = $urandom_range(0, 99);
        if (burst || pick < 40) return;
        len = (pick < 92) ? $urandom_range(1, 3) : $urandom_range(5, 40);
        start       <= 1'b0;
        i_action    <= 1'($urandom_range(0, 1));
        i_set_index <= SET_IN_BITS'($urandom_range(0, 255));
        i_tag       <= TAG_IN_BITS'($urandom_range(0, 20'hFFFFF));
        repeat (len) @(negedge i_clk);
    endtask

    initial begin
        logic [TAG_IN_BITS-1:0] tag_pool[8];
        logic [SET_IN_BITS-1:0] hot_base;
        logic [SET_IN_BITS-1:0] set_pick;
        int                     pool_n;
        int                     lock_odds;
        int                     idx;
        int                     sent;
        bit                     burst;
        logic [SET_IN_BITS-1:0] dir_set;

        start       = 1'b0;
        i_action    = ACT_LOOKUP;
        i_set_index = '0;
        i_tag       = '0;
        tag_pool    = '{default: '0};
        i_rst_n     = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: fills, hit, lowest-way tie, locked victim skipped, all ways locked
        for (int k = 0; k < 2; k++) begin
            dir_set = (k == 0) ? 8'd0 : 8'd255;
            send_item(ACT_LOOKUP, dir_set, 20'h00000); idle_gap(1'b0); // fill way 0
            send_item(ACT_LOOKUP, dir_set, 20'hFFFFF); idle_gap(1'b0); // fill way 1
            send_item(ACT_LOOKUP, dir_set, 20'h00000); idle_gap(1'b0); // hit way 0
            send_item(ACT_LOCK,   dir_set, 20'h00001); idle_gap(1'b0); // fill way 2, lock
            send_item(ACT_LOOKUP, dir_set, 20'h80000); idle_gap(1'b0); // fill way 3
            send_item(ACT_LOOKUP, dir_set, 20'h00003); idle_gap(1'b0); // replace, tie
            send_item(ACT_LOCK,   dir_set, 20'h00004); idle_gap(1'b0); // replace, lock
            send_item(ACT_LOCK,   dir_set, 20'h00000); idle_gap(1'b0); // hit, lock
            send_item(ACT_LOCK,   dir_set, 20'h80000); idle_gap(1'b0); // last way locked
            send_item(ACT_LOOKUP, dir_set, 20'h00005); idle_gap(1'b0); // all locked
            send_item(ACT_LOCK,   dir_set, 20'h00005); idle_gap(1'b0); // all locked, no lock
        end

        // Build up one way's count, then evict it as the only unlocked candidate
        send_item(ACT_LOCK,   SAT_SET, 20'h11111);
        send_item(ACT_LOCK,   SAT_SET, 20'h22222);
        send_item(ACT_LOCK,   SAT_SET, 20'h33333);
        send_item(ACT_LOOKUP, SAT_SET, 20'h44444);
        repeat (20) send_item(ACT_LOOKUP, SAT_SET, 20'h44444);
        send_item(ACT_LOOKUP, SAT_SET, 20'h55555);
        send_item(ACT_LOOKUP, SAT_SET, 20'h55555);
        idle_gap(1'b0);

        // Random rounds: a few hot sets with a small tag pool, plus noise
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pool_n    = $urandom_range(3, 8);
            hot_base  = SET_IN_BITS'($urandom_range(0, 255));
            lock_odds = $urandom_range(6, 40);
            burst     = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 8; k++) begin
                case ($urandom_range(0, 7))
                    0: tag_pool[k] = '0;
                    1: tag_pool[k] = '1;
                    2, 3: tag_pool[k] = tag_pool[0] ^ (TAG_IN_BITS'(1) << $urandom_range(0, 19));
                    default: tag_pool[k] = TAG_IN_BITS'($urandom_range(0, 20'hFFFFF));
                endcase
            end
            repeat ($urandom_range(40, 120)) begin
                if ($urandom_range(0, 4) == 0) begin
                    send_item(1'($urandom_range(0, 1)), SET_IN_BITS'($urandom_range(0, 255)),
                              TAG_IN_BITS'($urandom_range(0, 20'hFFFFF)));
                end else begin
                    // skew toward low pool entries so use counts differ
                    idx      = $urandom_range(0, pool_n - 1);
                    idx      = (idx < $urandom_range(0, pool_n - 1)) ? idx :
                               $urandom_range(0, pool_n - 1);
                    set_pick = hot_base + SET_IN_BITS'($urandom_range(0, 3));
                    send_item(($urandom_range(0, lock_odds - 1) == 0) ? ACT_LOCK : ACT_LOOKUP,
                              set_pick, tag_pool[idx]);
                end
                idle_gap(burst);
                sent++;
            end
        end

        // Drain
        start <= 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("lfu_cache_way_replacement_unit regression: pass");
        end else begin
            $display("lfu_cache_way_replacement_unit regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/lfu_cwr_pkg.sv
src/lfu_cwr_ctrl.sv
src/lfu_cwr_dp.sv
src/lfu_cache_way_replacement_unit.sv
src/lfu_cwr_checker.sv
tb/lfu_cwr_checker.sv
tb/testbench.sv
